@@ design/slc_pkg.sv @@
package slc_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int RANK_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W = 32;
    localparam int RCNT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_KEEP   = 2'd2;
    localparam logic [1:0] KIND_DROP   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the request
        logic match;       // register the parallel compare
        logic report_hit;  // hit and stored payload into the result
        logic touch;       // make the hit entry most recent
        logic mark;        // set keep mark of the hit entry
        logic evict;       // drop the oldest entry
        logic insert;      // write the new entry into the first free slot
        logic sweep;       // process one slot of a session sweep
        logic publish;     // move the result into the output register
    } slc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        logic       hit;
        logic       full;
        logic       sweep_end;
    } slc_stat_t;

    function automatic logic [IDX_W-1:0] first_set(input logic [DEPTH-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ design/slc_ctrl.sv @@
module slc_ctrl
    import slc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  slc_stat_t stat,
    output slc_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_ACT    = 3'd2;
    localparam logic [2:0] S_EVICT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH: begin
                cmd.match  = 1'b1;
                state_next = S_ACT;
            end
            S_ACT: begin
                case (stat.kind)
                    KIND_LOOKUP: begin
                        cmd.report_hit = stat.hit;
                        cmd.touch      = stat.hit;
                        state_next     = S_DONE;
                    end
                    KIND_ADD: begin
                        cmd.report_hit = stat.hit;
                        if (stat.hit) begin
                            state_next = S_DONE;
                        end else if (stat.full) begin
                            state_next = S_EVICT;
                        end else begin
                            state_next = S_INSERT;
                        end
                    end
                    KIND_KEEP: begin
                        cmd.mark   = stat.hit;
                        state_next = stat.last ? S_SWEEP : S_DONE;
                    end
                    default: begin
                        state_next = S_SWEEP;
                    end
                endcase
            end
            S_EVICT: begin
                cmd.evict  = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ design/slc_dp.sv @@
module slc_dp
    import slc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic [1:0]        s_kind,
    input  logic [DATA_W-1:0] s_session_key,
    input  logic [DATA_W-1:0] s_item_id,
    input  logic [DATA_W-1:0] s_payload,
    input  logic              s_last,
    input  slc_cmd_t          cmd,
    output slc_stat_t         stat,
    output logic              m_hit,
    output logic [DATA_W-1:0] m_found_payload,
    output logic              m_added,
    output logic              m_evicted,
    output logic [DATA_W-1:0] m_evicted_session,
    output logic [DATA_W-1:0] m_evicted_item,
    output logic [RCNT_W-1:0] m_removed_count
);

    // entry storage
    logic [DEPTH-1:0]     valid_reg, valid_next;
    logic [DEPTH-1:0]     kept_reg, kept_next;
    logic [RANK_W-1:0]    rank_reg  [DEPTH];
    logic [RANK_W-1:0]    rank_next [DEPTH];
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [KEY_WIDTH-1:0] sess_reg   [DEPTH];
    logic [KEY_WIDTH-1:0] item_reg   [DEPTH];
    logic [DATA_W-1:0]    handle_reg [DEPTH];

    // request being worked on
    logic [1:0]           kind_reg;
    logic [KEY_WIDTH-1:0] skey_reg;
    logic [KEY_WIDTH-1:0] sitem_reg;
    logic [DATA_W-1:0]    pay_reg;
    logic                 last_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [DEPTH-1:0]     smatch_reg;
    logic [IDX_W-1:0]     sweep_idx_reg;

    // result being built
    logic                 r_hit_reg, r_added_reg, r_ev_reg;
    logic [DATA_W-1:0]    r_fpay_reg;
    logic [KEY_WIDTH-1:0] r_evs_reg, r_evi_reg;
    logic [RCNT_W-1:0]    r_removed_reg;

    logic [DEPTH-1:0]     key_match, sess_match, oldest_vec;
    logic [IDX_W-1:0]     oldest_idx, free_idx, tgt_idx;
    logic                 oldest_any, free_any;
    logic [RANK_W-1:0]    tgt_rank;
    logic [CMP_W-1:0]     eff_cap;
    logic                 sweep_drop, sweep_unmark, drop_en, dec_en;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            sess_match[i] = valid_reg[i] && (sess_reg[i] == skey_reg);
            key_match[i]  = sess_match[i] && (item_reg[i] == sitem_reg);
            oldest_vec[i] = valid_reg[i] && (rank_reg[i] == '0);
        end
    end

    assign oldest_any = |oldest_vec;
    assign oldest_idx = first_set(oldest_vec);
    assign free_any   = ~&valid_reg;
    assign free_idx   = first_set(~valid_reg);

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(DEPTH)) begin
            eff_cap = CMP_W'(DEPTH);
        end else begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign sweep_drop   = cmd.sweep && valid_reg[sweep_idx_reg] && smatch_reg[sweep_idx_reg]
                          && !(kind_reg == KIND_KEEP && kept_reg[sweep_idx_reg]);
    assign sweep_unmark = cmd.sweep && valid_reg[sweep_idx_reg] && smatch_reg[sweep_idx_reg]
                          && (kind_reg == KIND_KEEP) && kept_reg[sweep_idx_reg];
    assign drop_en      = (cmd.evict && oldest_any) || sweep_drop;
    assign dec_en       = drop_en || cmd.touch;

    always_comb begin
        if (cmd.evict) begin
            tgt_idx = oldest_idx;
        end else if (cmd.sweep) begin
            tgt_idx = sweep_idx_reg;
        end else begin
            tgt_idx = hit_idx_reg;
        end
    end

    assign tgt_rank = rank_reg[tgt_idx];

    always_comb begin
        valid_next = valid_reg;
        kept_next  = kept_reg;
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++) begin
            rank_next[i] = rank_reg[i];
        end
        // close the gap left above the removed or promoted entry
        if (dec_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (valid_reg[i] && (rank_reg[i] > tgt_rank)) begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
        end
        if (cmd.touch) begin
            rank_next[hit_idx_reg] = RANK_W'(count_reg - 1'b1);
        end
        if (cmd.mark) begin
            kept_next[hit_idx_reg] = 1'b1;
        end
        if (sweep_unmark) begin
            kept_next[sweep_idx_reg] = 1'b0;
        end
        if (drop_en) begin
            valid_next[tgt_idx] = 1'b0;
            kept_next[tgt_idx]  = 1'b0;
            if (count_reg != '0) begin
                count_next = count_reg - 1'b1;
            end
        end
        if (cmd.insert && free_any) begin
            valid_next[free_idx] = 1'b1;
            kept_next[free_idx]  = 1'b0;
            rank_next[free_idx]  = RANK_W'(count_reg);
            count_next           = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            kept_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            for (int i = 0; i < DEPTH; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            kept_reg  <= kept_next;
            count_reg <= count_next;
            for (int i = 0; i < DEPTH; i++) begin
                rank_reg[i] <= rank_next[i];
            end
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert && free_any) begin
            sess_reg[free_idx]   <= skey_reg;
            item_reg[free_idx]   <= sitem_reg;
            handle_reg[free_idx] <= pay_reg;
        end
        if (cmd.load) begin
            kind_reg      <= s_kind;
            skey_reg      <= s_session_key[KEY_WIDTH-1:0];
            sitem_reg     <= s_item_id[KEY_WIDTH-1:0];
            pay_reg       <= s_payload;
            last_reg      <= s_last;
            sweep_idx_reg <= '0;
            r_hit_reg     <= 1'b0;
            r_fpay_reg    <= '0;
            r_added_reg   <= 1'b0;
            r_ev_reg      <= 1'b0;
            r_evs_reg     <= '0;
            r_evi_reg     <= '0;
            r_removed_reg <= '0;
        end
        if (cmd.match) begin
            hit_reg     <= |key_match;
            hit_idx_reg <= first_set(key_match);
            smatch_reg  <= sess_match;
        end
        if (cmd.report_hit) begin
            r_hit_reg  <= 1'b1;
            r_fpay_reg <= handle_reg[hit_idx_reg];
        end
        if (cmd.evict && oldest_any) begin
            r_ev_reg  <= 1'b1;
            r_evs_reg <= sess_reg[oldest_idx];
            r_evi_reg <= item_reg[oldest_idx];
        end
        if (cmd.insert && free_any) begin
            r_added_reg <= 1'b1;
            r_fpay_reg  <= pay_reg;
        end
        if (cmd.sweep) begin
            sweep_idx_reg <= sweep_idx_reg + 1'b1;
        end
        if (sweep_drop && (r_removed_reg != '1)) begin
            r_removed_reg <= r_removed_reg + 1'b1;
        end
        if (cmd.publish) begin
            m_hit             <= r_hit_reg;
            m_found_payload   <= r_fpay_reg;
            m_added           <= r_added_reg;
            m_evicted         <= r_ev_reg;
            m_evicted_session <= DATA_W'(r_evs_reg);
            m_evicted_item    <= DATA_W'(r_evi_reg);
            m_removed_count   <= r_removed_reg;
        end
    end

    assign stat.kind      = kind_reg;
    assign stat.last      = last_reg;
    assign stat.hit       = hit_reg;
    assign stat.full      = CMP_W'(count_reg) >= eff_cap;
    assign stat.sweep_end = (sweep_idx_reg == IDX_W'(DEPTH - 1));

endmodule

@@ design/session_keyed_lru_cache.sv @@
// Request flow: a lookup, a keep mark without last and an add that hits go from the
// match to the result; an add into a free slot inserts first; an add that evicts
// drops the oldest entry, then inserts; a sweep or a session drop walks one slot per
// cycle. One request at a time: a new one is taken in after the result is published.
// Reset (aresetn low, synchronous): cache empty, recency cleared, capacity 16,
// no result pending. Entry keys and payloads are not cleared.
module session_keyed_lru_cache
    import slc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // capacity register
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic [DATA_W-1:0] s_session_key,
    input  logic [DATA_W-1:0] s_item_id,
    input  logic [DATA_W-1:0] s_payload,
    input  logic              s_last,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [DATA_W-1:0] m_found_payload,
    output logic              m_added,
    output logic              m_evicted,
    output logic [DATA_W-1:0] m_evicted_session,
    output logic [DATA_W-1:0] m_evicted_item,
    output logic [RCNT_W-1:0] m_removed_count
);

    // The controller steps each request through match, action and publish;
    // the datapath holds the entries, the recency ranks and the output register.
    // A result sits in the output register while the next request is taken in.
    slc_cmd_t  cmd;
    slc_stat_t stat;

    slc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    slc_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_kind            (s_kind),
        .s_session_key     (s_session_key),
        .s_item_id         (s_item_id),
        .s_payload         (s_payload),
        .s_last            (s_last),
        .cmd               (cmd),
        .stat              (stat),
        .m_hit             (m_hit),
        .m_found_payload   (m_found_payload),
        .m_added           (m_added),
        .m_evicted         (m_evicted),
        .m_evicted_session (m_evicted_session),
        .m_evicted_item    (m_evicted_item),
        .m_removed_count   (m_removed_count)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import slc_pkg::*;

    // Keys are compared on their low KEY_WIDTH bits only.
    localparam logic [DATA_W-1:0] KEY_MASK = DATA_W'({KEY_WIDTH{1'b1}});
    // A sweep or drop walks every slot, so that is the slowest request.
    localparam int SETTLE_CYCLES = 3 + DEPTH + 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int NUM_PHASES = 6;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] skey;
        logic [DATA_W-1:0] item;
        logic [DATA_W-1:0] pay;
        logic              last;
    } cache_req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] fpay;
        logic              added;
        logic              evicted;
        logic [DATA_W-1:0] ev_sess;
        logic [DATA_W-1:0] ev_item;
        logic [RCNT_W-1:0] removed;
    } cache_rsp_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_kind = KIND_LOOKUP;
    logic [DATA_W-1:0] s_session_key = '0;
    logic [DATA_W-1:0] s_item_id = '0;
    logic [DATA_W-1:0] s_payload = '0;
    logic              s_last = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_hit;
    logic [DATA_W-1:0] m_found_payload;
    logic              m_added;
    logic              m_evicted;
    logic [DATA_W-1:0] m_evicted_session;
    logic [DATA_W-1:0] m_evicted_item;
    logic [RCNT_W-1:0] m_removed_count;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    session_keyed_lru_cache i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_session_key     (s_session_key),
        .s_item_id         (s_item_id),
        .s_payload         (s_payload),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_found_payload   (m_found_payload),
        .m_added           (m_added),
        .m_evicted         (m_evicted),
        .m_evicted_session (m_evicted_session),
        .m_evicted_item    (m_evicted_item),
        .m_removed_count   (m_removed_count)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the cache contents and the capacity register
    // ------------------------------------------------------------------
    logic              ent_valid [DEPTH];
    logic [DATA_W-1:0] ent_sess  [DEPTH];
    logic [DATA_W-1:0] ent_item  [DEPTH];
    logic [DATA_W-1:0] ent_hdl   [DEPTH];
    logic              ent_kept  [DEPTH];
    int                ent_rank  [DEPTH];   // 0 = oldest, ent_count-1 = newest
    int                ent_count;
    logic [CAP_W-1:0]  cap_reg;

    cache_req_t req_q[$];        // requests waiting to be offered
    cache_rsp_t outcome_q[$];    // predicted results, oldest first

    int accepted;
    int results_seen;
    int mismatches;
    int hit_seen;
    int evict_seen;
    int removed_total;

    // Remove one entry and close the gap it leaves in the recency order.
    function automatic void unlink(input int slot);
        int r;
        r = ent_rank[slot];
        ent_valid[slot] = 1'b0;
        ent_kept[slot] = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (ent_valid[i] && ent_rank[i] > r) begin
                ent_rank[i]--;
            end
        end
        if (ent_count > 0) begin
            ent_count--;
        end
    endfunction

    // Apply one request to the shadow cache and return the result it must produce.
    function automatic cache_rsp_t cache_apply(input cache_req_t rq);
        cache_rsp_t        rs;
        logic [DATA_W-1:0] sk;
        logic [DATA_W-1:0] it;
        int                slot;
        int                cap_eff;
        int                r;
        int                removed;
        bit                done;
        rs = '0;
        removed = 0;
        sk = rq.skey & KEY_MASK;
        it = rq.item & KEY_MASK;
        slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (ent_valid[i] && ent_sess[i] == sk && ent_item[i] == it) begin
                slot = i;
            end
        end
        case (rq.kind)
            KIND_LOOKUP: begin
                if (slot >= 0) begin
                    rs.hit = 1'b1;
                    rs.fpay = ent_hdl[slot];
                    // move to the newest position
                    r = ent_rank[slot];
                    for (int i = 0; i < DEPTH; i++) begin
                        if (ent_valid[i] && ent_rank[i] > r) begin
                            ent_rank[i]--;
                        end
                    end
                    ent_rank[slot] = ent_count - 1;
                end
            end
            KIND_ADD: begin
                if (slot >= 0) begin
                    // already present: report it, leave payload and order alone
                    rs.hit = 1'b1;
                    rs.fpay = ent_hdl[slot];
                end else begin
                    cap_eff = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
                    // even when the count is above capacity only one entry goes
                    if (ent_count >= cap_eff) begin
                        done = 1'b0;
                        for (int i = 0; i < DEPTH; i++) begin
                            if (!done && ent_valid[i] && ent_rank[i] == 0) begin
                                rs.evicted = 1'b1;
                                rs.ev_sess = ent_sess[i];
                                rs.ev_item = ent_item[i];
                                unlink(i);
                                done = 1'b1;
                            end
                        end
                    end
                    done = 1'b0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!done && !ent_valid[i]) begin
                            ent_valid[i] = 1'b1;
                            ent_kept[i] = 1'b0;
                            ent_sess[i] = sk;
                            ent_item[i] = it;
                            ent_hdl[i] = rq.pay;
                            ent_rank[i] = ent_count;
                            ent_count++;
                            rs.added = 1'b1;
                            rs.fpay = rq.pay;
                            done = 1'b1;
                        end
                    end
                end
            end
            KIND_KEEP: begin
                if (slot >= 0) begin
                    ent_kept[slot] = 1'b1;
                end
                // last mark of a run: unmarked entries of the session go,
                // marks of the survivors are cleared
                if (rq.last) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (ent_valid[i] && ent_sess[i] == sk) begin
                            if (ent_kept[i]) begin
                                ent_kept[i] = 1'b0;
                            end else begin
                                unlink(i);
                                removed++;
                            end
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (ent_valid[i] && ent_sess[i] == sk) begin
                        unlink(i);
                        removed++;
                    end
                end
            end
        endcase
        if (removed > 31) begin
            removed = 31;
        end
        rs.removed = RCNT_W'(removed);
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers queued requests, idles ~17% outside the calm window
    // ------------------------------------------------------------------
    cache_req_t cur_req;

    always @(posedge aclk) begin : drive_proc
        logic       held;
        logic       calm;
        cache_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            held = s_valid;
            if (s_valid && s_ready) begin
                // prediction runs in acceptance order; block handles one request at a time
                outcome_q = {outcome_q, cache_apply(cur_req)};
                accepted++;
                held = 1'b0;
            end
            calm = (accepted >= 500 && accepted < 620);
            if (!held) begin
                if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                    nxt = req_q.pop_front();
                    cur_req = nxt;
                    s_kind <= nxt.kind;
                    s_session_key <= nxt.skey;
                    s_item_id <= nxt.item;
                    s_payload <= nxt.pay;
                    s_last <= nxt.last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares each result against the oldest prediction.
    // Also owns m_ready, including one long hold-off that backs up the block.
    // ------------------------------------------------------------------
    task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    int stall_left = 0;
    bit stall_done = 1'b0;

    always @(posedge aclk) begin : watch_proc
        cache_rsp_t want;
        logic       calm;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                hit_seen += m_hit;
                evict_seen += m_evicted;
                removed_total += m_removed_count;
                if (outcome_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected nothing actual hit=%b pay=%h",
                             $time, m_hit, m_found_payload);
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("hit", want.hit, m_hit);
                    check_field("found_payload", want.fpay, m_found_payload);
                    check_field("added", want.added, m_added);
                    check_field("evicted", want.evicted, m_evicted);
                    check_field("evicted_session", want.ev_sess, m_evicted_session);
                    check_field("evicted_item", want.ev_item, m_evicted_item);
                    check_field("removed_count", want.removed, m_removed_count);
                end
            end
            calm = (results_seen >= 500 && results_seen < 620);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!stall_done && results_seen >= 250) begin
                // long hold-off while the driver keeps offering
                stall_done = 1'b1;
                stall_left = 80;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] k, input logic [DATA_W-1:0] sk,
                             input logic [DATA_W-1:0] it, input logic [DATA_W-1:0] p,
                             input logic l);
        cache_req_t rq;
        rq.kind = k;
        rq.skey = sk;
        rq.item = it;
        rq.pay = p;
        rq.last = l;
        req_q = {req_q, rq};
    endtask

    // Everything offered, accepted and answered: safe to touch the register.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (req_q.size() != 0 || s_valid || outcome_q.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = v;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] sess_pool [4];
    logic [DATA_W-1:0] item_pool [8];

    initial begin : stim_proc
        int                n;
        int                r;
        int                len;
        logic [DATA_W-1:0] sk;
        logic [CAP_W-1:0]  phase_cap [NUM_PHASES];

        for (int i = 0; i < DEPTH; i++) begin
            ent_valid[i] = 1'b0;
            ent_kept[i] = 1'b0;
            ent_rank[i] = 0;
            ent_sess[i] = '0;
            ent_item[i] = '0;
            ent_hdl[i] = '0;
        end
        ent_count = 0;
        cap_reg = CAP_RESET;

        // small key pools so hits, sweeps and evictions happen often;
        // all-zero and all-one keys included
        sess_pool[0] = '0;
        sess_pool[1] = '1;
        sess_pool[2] = $urandom;
        sess_pool[3] = $urandom;
        item_pool[0] = '0;
        item_pool[1] = '1;
        for (int i = 2; i < 8; i++) begin
            item_pool[i] = $urandom;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part, capacity at its reset value ---
        queue_req(KIND_ADD, sess_pool[0], item_pool[0], '0, 1'b0);
        queue_req(KIND_ADD, sess_pool[0], item_pool[2], $urandom, 1'b1);
        queue_req(KIND_ADD, sess_pool[0], item_pool[3], $urandom, 1'b0);
        queue_req(KIND_ADD, sess_pool[1], item_pool[1], '1, 1'b1);
        queue_req(KIND_LOOKUP, sess_pool[0], item_pool[0], $urandom, 1'b0);   // hit
        queue_req(KIND_LOOKUP, sess_pool[0], item_pool[5], $urandom, 1'b0);   // miss
        queue_req(KIND_ADD, sess_pool[0], item_pool[2], $urandom, 1'b0);      // already present
        queue_req(KIND_KEEP, sess_pool[0], item_pool[2], $urandom, 1'b0);
        // last mark names an absent id but still sweeps the session
        queue_req(KIND_KEEP, sess_pool[0], item_pool[6], $urandom, 1'b1);
        queue_req(KIND_LOOKUP, sess_pool[0], item_pool[2], $urandom, 1'b1);
        queue_req(KIND_KEEP, sess_pool[1], item_pool[1], $urandom, 1'b1);     // keeps all
        queue_req(KIND_KEEP, $urandom, $urandom, $urandom, 1'b1);             // unknown session
        queue_req(KIND_DROP, $urandom, $urandom, $urandom, 1'b0);             // unknown session
        queue_req(KIND_DROP, sess_pool[1], item_pool[4], $urandom, 1'b1);
        queue_req(KIND_LOOKUP, sess_pool[1], item_pool[1], $urandom, 1'b0);
        wait_idle();

        // two slots: adds push the oldest out, a lookup refreshes recency
        write_capacity(CAP_W'(2));
        queue_req(KIND_ADD, sess_pool[2], item_pool[3], $urandom, 1'b0);
        queue_req(KIND_ADD, sess_pool[2], item_pool[4], $urandom, 1'b0);
        queue_req(KIND_LOOKUP, sess_pool[2], item_pool[3], $urandom, 1'b0);
        queue_req(KIND_ADD, sess_pool[3], item_pool[5], $urandom, 1'b0);
        queue_req(KIND_LOOKUP, sess_pool[0], item_pool[2], $urandom, 1'b0);
        wait_idle();

        // zero behaves as one; count is above capacity, still a single eviction
        write_capacity(CAP_W'(0));
        queue_req(KIND_ADD, sess_pool[1], item_pool[0], $urandom, 1'b0);
        queue_req(KIND_ADD, sess_pool[3], item_pool[7], $urandom, 1'b0);
        wait_idle();

        // --- random phases over several capacity settings ---
        phase_cap[0] = CAP_W'(31);                       // clamps to DEPTH, fills up
        phase_cap[1] = CAP_W'(3);                        // far below the count
        phase_cap[2] = CAP_W'(1);
        phase_cap[3] = CAP_W'(16);
        phase_cap[4] = CAP_W'($urandom_range(4, 15));
        phase_cap[5] = CAP_W'($urandom_range(17, 30));   // above DEPTH

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(phase_cap[ph]);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                sk = sess_pool[$urandom_range(0, 3)];
                if (r < 38) begin
                    queue_req(KIND_LOOKUP, sk, item_pool[$urandom_range(0, 7)], $urandom,
                              1'($urandom_range(0, 1)));
                    n++;
                end else if (r < 72) begin
                    queue_req(KIND_ADD, sk, item_pool[$urandom_range(0, 7)], $urandom,
                              1'($urandom_range(0, 1)));
                    n++;
                end else if (r < 86) begin
                    // well-formed keep run, last flag on the final mark
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        queue_req(KIND_KEEP, sk, item_pool[$urandom_range(0, 7)], $urandom,
                                  k == len - 1);
                    end
                    n += len;
                end else if (r < 90) begin
                    queue_req(KIND_DROP, sk, $urandom, $urandom, 1'($urandom_range(0, 1)));
                    n++;
                end else begin
                    // noise: any kind, stray keys, runs that never close
                    queue_req(2'($urandom_range(0, 3)),
                              ($urandom_range(0, 1) != 0) ? sk : DATA_W'($urandom),
                              $urandom, $urandom, 1'($urandom_range(0, 1)));
                    n++;
                end
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests over %0d capacity settings incl. 0, 1, 16 and 31",
                 accepted, NUM_PHASES + 3);
        $display("results %0d: %0d hits, %0d evictions, %0d entries swept or dropped",
                 results_seen, hit_seen, evict_seen, removed_total);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog_proc
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/slc_pkg.sv
design/slc_ctrl.sv
design/slc_dp.sv
design/session_keyed_lru_cache.sv
tb/sv/tb_top.sv
